>>> sv/ccpg_pkg.sv
package ccpg_pkg;

	localparam int ZFRAC = 30;
	localparam int ANGW  = 41;
	localparam int ZW    = 42;
	localparam int CW    = 33;
	localparam int MAW   = 34;
	localparam int MBW   = 17;
	localparam int MPW   = MAW + MBW;
	localparam int RW    = 29;
	localparam int PW    = 64;
	localparam int DENW  = 29;
	localparam int OW    = 13;
	localparam int TABLE_LEN = 20;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [ZW-1:0] DEG360 = 42'sd360 <<< ZFRAC;
	localparam logic signed [ZW-1:0] DEG270 = 42'sd270 <<< ZFRAC;
	localparam logic signed [ZW-1:0] DEG180 = 42'sd180 <<< ZFRAC;
	localparam logic signed [ZW-1:0] DEG90  = 42'sd90 <<< ZFRAC;

	localparam logic [22:0] STEP_NUM_K = 23'd4500000;
	localparam logic [18:0] STEP_DEN_K = 19'd314159;

	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_RADIUS    = 3'd2,
		REG_ROTATION  = 3'd3,
		REG_THICKNESS = 3'd4,
		REG_COLOR     = 3'd5
	} reg_index_t;

	function automatic logic [35:0] atan_deg(input logic [4:0] i);
		logic [35:0] v;
		case (i)
			5'd0:  v = 36'd48318382080;
			5'd1:  v = 36'd28524006506;
			5'd2:  v = 36'd15071301663;
			5'd3:  v = 36'd7650428050;
			5'd4:  v = 36'd3840059796;
			5'd5:  v = 36'd1921901881;
			5'd6:  v = 36'd961185452;
			5'd7:  v = 36'd480629869;
			5'd8:  v = 36'd240318601;
			5'd9:  v = 36'd120159761;
			5'd10: v = 36'd60079938;
			5'd11: v = 36'd30039487;
			5'd12: v = 36'd15019745;
			5'd13: v = 36'd7509872;
			5'd14: v = 36'd3754936;
			5'd15: v = 36'd1877468;
			5'd16: v = 36'd938734;
			5'd17: v = 36'd469367;
			5'd18: v = 36'd234684;
			5'd19: v = 36'd117342;
			default: v = 36'd0;
		endcase
		return v;
	endfunction

	// divide by 2^46 toward zero, keep 13 bits
	function automatic logic [OW-1:0] trunc46(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		q = p >>> 46;
		if (p[PW-1] && (p[45:0] != 46'd0)) begin
			q = q + 64'sd1;
		end
		return q[OW-1:0];
	endfunction

endpackage

>>> sv/ccpg_div.sv
module ccpg_div #(
	parameter int NW = 45,
	parameter int DW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CNTW = $clog2(NW + 1);

	logic [DW:0]     rem_q;
	logic [NW-1:0]   quot_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;

	assign trial = {rem_q[DW-1:0], quot_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q  <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> sv/ccpg_cordic.sv
module ccpg_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ccpg_pkg::ANGW-1:0]         angle,
	output logic                              done,
	output logic signed [ccpg_pkg::CW-1:0]    cos_v,
	output logic signed [ccpg_pkg::CW-1:0]    sin_v
);
	import ccpg_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int ITW   = $clog2(NSTEP);

	typedef enum logic [2:0] {
		CS_IDLE = 3'b001,
		CS_RED  = 3'b010,
		CS_ROT  = 3'b100
	} cstate_t;

	cstate_t              state_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [ITW-1:0]       it_q;
	logic                 neg_q;
	logic                 done_q;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] at;

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = $signed({6'b0, atan_deg(5'(it_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				CS_IDLE: if (start) state_q <= CS_RED;
				CS_RED:  if (z_q < DEG360) state_q <= CS_ROT;
				CS_ROT: if (it_q == ITW'(NSTEP - 1)) begin
					state_q <= CS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: if (start) z_q <= $signed({1'b0, angle});
			CS_RED: begin
				if (z_q >= DEG360) begin
					z_q <= z_q - DEG360;
				end else begin
					// fold into -90..90
					if (z_q >= DEG270) begin
						z_q   <= z_q - DEG360;
						neg_q <= 1'b0;
					end else if (z_q > DEG90) begin
						z_q   <= z_q - DEG180;
						neg_q <= 1'b1;
					end else begin
						neg_q <= 1'b0;
					end
					x_q  <= CORDIC_GAIN;
					y_q  <= '0;
					it_q <= '0;
				end
			end
			CS_ROT: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				it_q <= it_q + 1'b1;
				if (it_q == ITW'(NSTEP - 1)) begin
					cos_v <= neg_q ? -(x_q + (z_q[ZW-1] ? dx : -dx))
					               :  (x_q + (z_q[ZW-1] ? dx : -dx));
					sin_v <= neg_q ? -(y_q + (z_q[ZW-1] ? -dy : dy))
					               :  (y_q + (z_q[ZW-1] ? -dy : dy));
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;

endmodule

>>> sv/ccpg_mul.sv
module ccpg_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [ccpg_pkg::MAW-1:0] a,
	input  logic signed [ccpg_pkg::MBW-1:0] b,
	output logic signed [ccpg_pkg::MPW-1:0] p
);
	import ccpg_pkg::*;

	logic signed [MPW-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MPW'(a) * MPW'(b);
		end
	end

	assign p = p_q;

endmodule

>>> sv/cardioid_point_generator.sv
// Each accepted request produces one point of the rotated cardioid r = radius*(1+sin(angle+
// rotation)) around (center_x, center_y). Each point takes two sine/cosine evaluations on one
// shared CORDIC unit, each with angle reduction, rotation steps and a hand-off. Then the
// states S_MR to S_FIN drive five passes through one 34x17 multiplier and present the point,
// and S_IDLE takes the next request. A request that starts a run (restart, or the one after
// the last point) first runs a bit-serial divider for the angle step. in_stall is high while a
// point is in progress; the finished point sits in an output register so the next request can
// be taken meanwhile.
module cardioid_point_generator #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_en,
	input  logic [2:0]         write_index,
	input  logic [23:0]        write_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [12:0] point_x,
	output logic signed [12:0] point_y,
	output logic               last
);
	import ccpg_pkg::*;

	localparam int SW = FRAC_BITS + 10;
	localparam int AW = FRAC_BITS + 11;
	localparam int NW = FRAC_BITS + 29;
	localparam logic [AW-1:0] LIMIT = AW'(360) << FRAC_BITS;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DIV   = 13'b0000000000010,
		S_ANG1  = 13'b0000000000100,
		S_WAIT1 = 13'b0000000001000,
		S_ANG0  = 13'b0000000010000,
		S_WAIT0 = 13'b0000000100000,
		S_MR    = 13'b0000001000000,
		S_R16   = 13'b0000010000000,
		S_MXL   = 13'b0000100000000,
		S_MXH   = 13'b0001000000000,
		S_MYL   = 13'b0010000000000,
		S_MYH   = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t                state_q;
	logic [10:0]           center_x_q, center_y_q;
	logic [9:0]            radius_q;
	logic [8:0]            rotation_q;
	logic [5:0]            thick_q;
	logic [AW-1:0]         acc_q;
	logic [SW-1:0]         step_q;
	logic                  run_active_q;
	logic signed [CW-1:0]  s1_q;
	logic signed [RW-1:0]  r16_q;
	logic signed [PW-1:0]  sum_q;
	logic [OW-1:0]         px_q;
	logic                  out_valid_q;
	logic [OW-1:0]         point_x_q, point_y_q;
	logic                  last_q;

	logic                  in_acc;
	logic                  div_start, div_done;
	logic [NW-1:0]         div_num, div_quot;
	logic [DENW-1:0]       div_den;
	logic [9:0]            rad_nz;
	logic                  cor_start, cor_done;
	logic [ANGW-1:0]       a30, cor_angle;
	logic signed [CW-1:0]  cos_v, sin_v;
	logic                  mul_en;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [MPW-1:0] mul_p;
	logic signed [PW-1:0]  full;
	logic                  load;
	logic                  last_w;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// configuration registers; color is not stored here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= 10'd1;
			rotation_q <= '0;
			thick_q    <= 6'd1;
		end else if (write_en) begin
			case (write_index)
				REG_CENTER_X:  center_x_q <= write_data[10:0];
				REG_CENTER_Y:  center_y_q <= write_data[10:0];
				REG_RADIUS:    radius_q   <= write_data[9:0];
				REG_ROTATION:  rotation_q <= write_data[8:0];
				REG_THICKNESS: thick_q    <= write_data[5:0];
				default: ;
			endcase
		end
	end

	// step divider
	assign rad_nz    = (radius_q == 10'd0) ? 10'd1 : radius_q;
	assign div_num   = NW'(29'(thick_q) * 29'(STEP_NUM_K)) << FRAC_BITS;
	assign div_den   = DENW'(STEP_DEN_K) * DENW'(rad_nz);
	assign div_start = in_acc && (restart || !run_active_q);

	ccpg_div #(.NW(NW), .DW(DENW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	// sine / cosine
	assign a30       = ANGW'(acc_q) << (ZFRAC - FRAC_BITS);
	assign cor_angle = (state_q == S_ANG1) ? a30 + (ANGW'(rotation_q) << ZFRAC) : a30;
	assign cor_start = (state_q == S_ANG1) || (state_q == S_ANG0);

	ccpg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_angle),
		.done(cor_done), .cos_v(cos_v), .sin_v(sin_v)
	);

	// shared multiplier operands
	always_comb begin
		mul_en = 1'b1;
		mul_a  = MAW'(cos_v);
		mul_b  = $signed({2'b0, r16_q[14:0]});
		case (state_q)
			S_MR: begin
				mul_a = (MAW'(1) <<< ZFRAC) + MAW'(s1_q);
				mul_b = $signed({7'b0, radius_q});
			end
			S_MXL: ;
			S_MXH: mul_b = MBW'($signed(r16_q[RW-1:15]));
			S_MYL: mul_a = MAW'(sin_v);
			S_MYH: begin
				mul_a = MAW'(sin_v);
				mul_b = MBW'($signed(r16_q[RW-1:15]));
			end
			default: mul_en = 1'b0;
		endcase
	end

	ccpg_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p));

	assign full   = sum_q + (PW'(mul_p) <<< 15);
	assign load   = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign last_w = (acc_q + AW'(step_q)) > LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			run_active_q <= 1'b0;
			acc_q        <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_acc) begin
					if (div_start) begin
						acc_q        <= '0;
						run_active_q <= 1'b1;
						state_q      <= S_DIV;
					end else begin
						state_q <= S_ANG1;
					end
				end
				S_DIV: if (div_done) begin
					step_q  <= div_quot[SW-1:0];
					state_q <= S_ANG1;
				end
				S_ANG1:  state_q <= S_WAIT1;
				S_WAIT1: if (cor_done) state_q <= S_ANG0;
				S_ANG0:  state_q <= S_WAIT0;
				S_WAIT0: if (cor_done) state_q <= S_MR;
				S_MR:    state_q <= S_R16;
				S_R16:   state_q <= S_MXL;
				S_MXL:   state_q <= S_MXH;
				S_MXH:   state_q <= S_MYL;
				S_MYL:   state_q <= S_MYH;
				S_MYH:   state_q <= S_FIN;
				S_FIN: if (load) begin
					if (last_w) begin
						run_active_q <= 1'b0;
					end else begin
						acc_q <= acc_q + AW'(step_q);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WAIT1 && cor_done) s1_q <= sin_v;
		if (state_q == S_R16) r16_q <= RW'(mul_p >>> 14);
		if (state_q == S_MXH || state_q == S_MYH) sum_q <= PW'(mul_p);
		if (state_q == S_MYL) px_q <= OW'(center_x_q) + trunc46(full);
		if (load) begin
			point_x_q <= px_q;
			point_y_q <= OW'(center_y_q) + trunc46(full);
			last_q    <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign point_x   = $signed(point_x_q);
	assign point_y   = $signed(point_y_q);
	assign last      = last_q;

`ifndef SYNTH
	a_restart_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && restart) |=> (state_q == S_DIV))
		else $error("restart did not start the step divider");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_w) |=> !run_active_q)
		else $error("run still active after last point");

	a_angle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_active_q |-> (acc_q <= LIMIT))
		else $error("angle past full turn");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded point not presented");
`endif

endmodule

>>> sim/tb.sv
module tb;
	import ccpg_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	logic write_en;
	logic [2:0] write_index;
	logic [23:0] write_data;
	logic in_valid;
	logic in_stall;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic signed [12:0] point_x;
	logic signed [12:0] point_y;
	logic last;

	cardioid_point_generator DUT (
		.clk(clk), .arst_n(arst_n),
		.write_en(write_en), .write_index(write_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.point_x(point_x), .point_y(point_y), .last(last)
	);

	typedef struct {
		logic [12:0] px;
		logic [12:0] py;
		logic lst;
	} point_t;

	class point_scoreboard;
		bit [10:0] cx, cy;
		bit [9:0] rad;
		bit [8:0] rot;
		bit [5:0] thick;
		bit [23:0] col;
		longint unsigned acc, stp;
		bit active;
		point_t pending[$];
		int errors;
		int points;
		int runs_ended;

		function void set_reg(logic [2:0] idx, logic [23:0] v);
			case (idx)
				REG_CENTER_X: cx = v[10:0];
				REG_CENTER_Y: cy = v[10:0];
				REG_RADIUS: rad = v[9:0];
				REG_ROTATION: rot = v[8:0];
				REG_THICKNESS: thick = v[5:0];
				REG_COLOR: col = v;
				default: ;
			endcase
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function void sincos(longint unsigned a, output longint c, output longint s);
			longint z, x, y, dx, dy;
			longint tbl[20];
			bit neg;
			tbl = '{64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428050,
				64'sd3840059796, 64'sd1921901881, 64'sd961185452, 64'sd480629869,
				64'sd240318601, 64'sd120159761, 64'sd60079938, 64'sd30039487,
				64'sd15019745, 64'sd7509872, 64'sd3754936, 64'sd1877468, 64'sd938734,
				64'sd469367, 64'sd234684, 64'sd117342};
			z = longint'(a % (longint'(360) << 30));
			x = 652032874;
			y = 0;
			neg = 0;
			if (z >= (longint'(270) << 30)) z -= longint'(360) << 30;
			else if (z > (longint'(90) << 30)) begin
				z -= longint'(180) << 30;
				neg = 1;
			end
			for (int i = 0; i < 16; i++) begin
				dx = floor_shift(y, i);
				dy = floor_shift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= tbl[i];
				end else begin
					x += dx; y -= dy; z += tbl[i];
				end
			end
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function longint mul_div46(longint r16, longint t);
			logic signed [127:0] p;
			logic signed [127:0] q;
			p = 128'(r16) * 128'(t);
			q = p / (128'sd1 <<< 46);
			return longint'(q);
		endfunction

		function void note_request(bit rs);
			longint unsigned a30, r_eff;
			longint c1, s1, c0, s0, r16, px, py;
			point_t e;
			if (rs || !active) begin
				acc = 0;
				r_eff = rad ? rad : 1;
				stp = (((longint'(45) * thick) << 16) * 100000) / (314159 * r_eff);
				active = 1;
			end
			a30 = acc << 14;
			sincos(a30 + (longint'(rot) << 30), c1, s1);
			sincos(a30, c0, s0);
			r16 = floor_shift(longint'(rad) * ((longint'(1) << 30) + s1), 14);
			px = longint'(cx) + mul_div46(r16, c0);
			py = longint'(cy) + mul_div46(r16, s0);
			e.lst = (acc + stp) > (longint'(360) << 16);
			if (e.lst) active = 0;
			else acc += stp;
			e.px = px[12:0];
			e.py = py[12:0];
			pending.push_back(e);
		endfunction

		function void check_point(logic [12:0] x, logic [12:0] y, logic l);
			point_t e;
			points++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, x, y, l);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (l) runs_ended++;
			if (x !== e.px) begin
				$display("%0t: point_x expected %0d actual %0d", $time, e.px, x);
				errors++;
			end
			if (y !== e.py) begin
				$display("%0t: point_y expected %0d actual %0d", $time, e.py, y);
				errors++;
			end
			if (l !== e.lst) begin
				$display("%0t: last expected %0b actual %0b", $time, e.lst, l);
				errors++;
			end
		endfunction
	endclass

	point_scoreboard sb;
	int idle_pct;
	int quiet_cycles;

	initial clk = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		sb = new();
		sb.rad = 1;
		sb.thick = 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(restart);
			if (out_valid && !out_stall) sb.check_point(point_x, point_y, last);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles > 20000) begin
			$display("watchdog expired");
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
		write_en <= 1;
		write_index <= idx;
		write_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic send_request(input bit rs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic load_setup(input logic [10:0] x, input logic [10:0] y,
			input logic [9:0] r, input logic [8:0] rt, input logic [5:0] th,
			input logic [23:0] c);
		drain();
		write_reg(REG_CENTER_X, 24'(x));
		write_reg(REG_CENTER_Y, 24'(y));
		write_reg(REG_RADIUS, 24'(r));
		write_reg(REG_ROTATION, 24'(rt));
		write_reg(REG_THICKNESS, 24'(th));
		write_reg(REG_COLOR, c);
		write_en <= 0;
	endtask

	initial begin
		arst_n = 0;
		write_en = 0;
		write_index = '0;
		write_data = '0;
		in_valid = 0;
		restart = 0;
		out_stall = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners
		load_setup(11'd2047, 11'd2047, 10'd1023, 9'd359, 6'd63, 24'hFFFFFF);
		repeat (4) send_request(0);
		send_request(1);
		load_setup(11'd0, 11'd0, 10'd0, 9'd511, 6'd0, 24'd0);
		repeat (3) send_request(0);
		load_setup(11'd1024, 11'd1024, 10'd1, 9'd0, 6'd63, 24'h00FF00);
		repeat (12) send_request(1'($urandom_range(1)));
		drain();
		write_reg(REG_UNUSED, 24'hABCDEF);
		write_en <= 0;

		// random idling, with one unbroken stretch in the second phase
		for (int ph = 0; ph < 12; ph++) begin
			idle_pct = (ph == 1) ? 0 : 11;
			if (ph == 0 || ph == 6)
				load_setup(11'($urandom), 11'($urandom), 10'($urandom_range(1, 3)),
					9'($urandom_range(359)), 6'($urandom_range(40, 63)), 24'($urandom));
			else if (ph == 11)
				load_setup(11'd0, 11'd0, 10'd1023, 9'd359, 6'd1, 24'($urandom));
			else
				load_setup(11'($urandom), 11'($urandom), 10'($urandom), 9'($urandom),
					6'($urandom), 24'($urandom));
			for (int i = 0; i < 80; i++) begin
				if (i == 40) drain();
				send_request($urandom_range(99) < 3);
			end
		end

		idle_pct = 0;
		drain();
		$display("checked %0d points, %0d curve ends, across corner and random settings",
			sb.points, sb.runs_ended);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

>>> cardioid_point_generator.f
sv/ccpg_pkg.sv
sv/ccpg_div.sv
sv/ccpg_cordic.sv
sv/ccpg_mul.sv
sv/cardioid_point_generator.sv
sim/tb.sv
